// ===== rtl/assert_macros.svh =====
// assertion macros for the segment intersection test core
// used by the top level only, needs a clock and an active-high reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SIT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sit assertion failed");

// next-cycle implication
`define SIT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sit assertion failed");

`endif

// ===== rtl/sit_pkg.sv =====
// shared constants and types of the segment intersection test core
// no dependencies
`default_nettype none

package sit_pkg;

  localparam int FIELD_WIDTH         = 32;
  localparam int COORD_WIDTH_DEFAULT = 32;
  localparam int TOL_WIDTH           = 32;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 32'd4295;

  // stage advance enables seen by the cross product lanes
  typedef struct packed {
    logic s2;
    logic s3;
  } sit_adv_t;

endpackage

`default_nettype wire

// ===== rtl/sit_if.sv =====
// channel interfaces: segment pair input, result output, tolerance write
// depends on sit_pkg
`default_nettype none

interface sit_in_if;
  logic valid;
  logic ready;
  logic signed [sit_pkg::FIELD_WIDTH-1:0] seg_a_start_x;
  logic signed [sit_pkg::FIELD_WIDTH-1:0] seg_a_start_y;
  logic signed [sit_pkg::FIELD_WIDTH-1:0] seg_a_end_x;
  logic signed [sit_pkg::FIELD_WIDTH-1:0] seg_a_end_y;
  logic signed [sit_pkg::FIELD_WIDTH-1:0] seg_b_start_x;
  logic signed [sit_pkg::FIELD_WIDTH-1:0] seg_b_start_y;
  logic signed [sit_pkg::FIELD_WIDTH-1:0] seg_b_end_x;
  logic signed [sit_pkg::FIELD_WIDTH-1:0] seg_b_end_y;

  modport source (
    output valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
           seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
    input  ready
  );
  modport sink (
    input  valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
           seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
    output ready
  );
endinterface

interface sit_out_if;
  logic valid;
  logic ready;
  logic intersects;
  logic boxes_overlap;
  logic b_meets_line_a;
  logic a_meets_line_b;

  modport source (
    output valid, intersects, boxes_overlap, b_meets_line_a, a_meets_line_b,
    input  ready
  );
  modport sink (
    input  valid, intersects, boxes_overlap, b_meets_line_a, a_meets_line_b,
    output ready
  );
endinterface

interface sit_cfg_if;
  logic valid;
  logic ready;
  logic [sit_pkg::TOL_WIDTH-1:0] on_line_tolerance;

  modport source (output valid, on_line_tolerance, input ready);
  modport sink (input valid, on_line_tolerance, output ready);
endinterface

`default_nettype wire

// ===== rtl/segment_intersection_test_core.sv =====
// segment intersection test: five-stage pipeline, one segment pair per cycle while result is not stalled
// Channels: seg_in takes a pair of segments (signed fixed-point endpoints,
// only the low COORD_WIDTH bits of each field are used, sign-extended);
// result gives intersects, boxes_overlap, b_meets_line_a, a_meets_line_b;
// cfg writes on_line_tolerance and is always ready.
// Throughput: one pair per cycle unless result stalls; stages are input
// register, differences and box test, multipliers, cross product subtract,
// flag output register.
// Each stage holds its item while the one after it is full and stalled, so a
// stall on result backs up through the valid bits and lowers seg_in.ready only
// once every stage is occupied; nothing is dropped or repeated.
// Reset clears all valid bits and sets the tolerance to 4295.
// The tolerance is compared against the exact cross product magnitude.
// Depends on sit_pkg, sit_if, sit_cross and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module segment_intersection_test_core #(
  parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  sit_in_if.sink    seg_in,
  sit_out_if.source result,
  sit_cfg_if.sink   cfg
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;

  logic [4:0] vld;
  logic [4:0] adv;

  logic [sit_pkg::TOL_WIDTH-1:0] tol;

  // stage 0: endpoints ax0 ay0 ax1 ay1 bx0 by0 bx1 by1
  logic signed [CW-1:0] pt [8];

  // stage 1
  logic signed [DW-1:0] dxa, dya, dxb, dyb;
  logic signed [DW-1:0] qx [4];
  logic signed [DW-1:0] qy [4];
  logic                 box1, box2, box3;
  logic                 box_x, box_y;

  logic [3:0] on, right;

  logic out_int, out_box, out_ba, out_ab;

  sit_pkg::sit_adv_t lane_adv;

  // flow control
  always_comb begin
    adv[4] = !vld[4] || result.ready;
    adv[3] = !vld[3] || adv[4];
    adv[2] = !vld[2] || adv[3];
    adv[1] = !vld[1] || adv[2];
    adv[0] = !vld[0] || adv[1];
    lane_adv.s2 = adv[2];
    lane_adv.s3 = adv[3];
  end

  assign seg_in.ready = adv[0];
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      tol <= sit_pkg::TOL_RESET;
    end else begin
      if (adv[0]) vld[0] <= seg_in.valid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
      if (adv[3]) vld[3] <= vld[2];
      if (adv[4]) vld[4] <= vld[3];
      if (cfg.valid) tol <= cfg.on_line_tolerance;
    end
  end

  // stage 0: input register
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pt[0] <= seg_in.seg_a_start_x[CW-1:0];
      pt[1] <= seg_in.seg_a_start_y[CW-1:0];
      pt[2] <= seg_in.seg_a_end_x[CW-1:0];
      pt[3] <= seg_in.seg_a_end_y[CW-1:0];
      pt[4] <= seg_in.seg_b_start_x[CW-1:0];
      pt[5] <= seg_in.seg_b_start_y[CW-1:0];
      pt[6] <= seg_in.seg_b_end_x[CW-1:0];
      pt[7] <= seg_in.seg_b_end_y[CW-1:0];
    end
  end

  // bounding boxes overlap when some a coordinate is <= some b and some is >= some b
  always_comb begin
    box_x = ((pt[0] <= pt[4]) || (pt[0] <= pt[6]) || (pt[2] <= pt[4]) || (pt[2] <= pt[6]))
         && ((pt[0] >= pt[4]) || (pt[0] >= pt[6]) || (pt[2] >= pt[4]) || (pt[2] >= pt[6]));
    box_y = ((pt[1] <= pt[5]) || (pt[1] <= pt[7]) || (pt[3] <= pt[5]) || (pt[3] <= pt[7]))
         && ((pt[1] >= pt[5]) || (pt[1] >= pt[7]) || (pt[3] >= pt[5]) || (pt[3] >= pt[7]));
  end

  // stage 1: differences and box flag; the box flag is carried on through stages 2 and 3
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      dxa   <= DW'(pt[2]) - DW'(pt[0]);
      dya   <= DW'(pt[3]) - DW'(pt[1]);
      dxb   <= DW'(pt[6]) - DW'(pt[4]);
      dyb   <= DW'(pt[7]) - DW'(pt[5]);
      qx[0] <= DW'(pt[4]) - DW'(pt[0]);
      qy[0] <= DW'(pt[5]) - DW'(pt[1]);
      qx[1] <= DW'(pt[6]) - DW'(pt[0]);
      qy[1] <= DW'(pt[7]) - DW'(pt[1]);
      qx[2] <= DW'(pt[0]) - DW'(pt[4]);
      qy[2] <= DW'(pt[1]) - DW'(pt[5]);
      qx[3] <= DW'(pt[2]) - DW'(pt[4]);
      qy[3] <= DW'(pt[3]) - DW'(pt[5]);
      box1  <= box_x && box_y;
    end
    if (adv[2]) box2 <= box1;
    if (adv[3]) box3 <= box2;
  end

  // stages 2 and 3: lanes 0,1 test b's endpoints against line a, lanes 2,3 the reverse
  for (genvar i = 0; i < 4; i++) begin : g_lane
    sit_cross #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_cross (
      .clk  (clk),
      .adv  (lane_adv),
      .dx   ((i < 2) ? dxa : dxb),
      .dy   ((i < 2) ? dya : dyb),
      .qx   (qx[i]),
      .qy   (qy[i]),
      .tol  (tol),
      .on   (on[i]),
      .right(right[i])
    );
  end

  // stage 4: output register
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      out_box <= box3;
      out_ba  <= on[0] || on[1] || (right[0] != right[1]);
      out_ab  <= on[2] || on[3] || (right[2] != right[3]);
      out_int <= box3 && (on[0] || on[1] || (right[0] != right[1]))
                      && (on[2] || on[3] || (right[2] != right[3]));
    end
  end

  assign result.valid          = vld[4];
  assign result.intersects     = out_int;
  assign result.boxes_overlap  = out_box;
  assign result.b_meets_line_a = out_ba;
  assign result.a_meets_line_b = out_ab;

  `SIT_ASSERT_IMP(a_result_consistent, clk, rst, result.valid && result.intersects, result.boxes_overlap && result.b_meets_line_a && result.a_meets_line_b)
  `SIT_ASSERT_NXT(a_transfer_lands, clk, rst, seg_in.valid && seg_in.ready, vld[0])
  `SIT_ASSERT_NXT(a_stall_holds, clk, rst, vld[3] && !adv[3], vld[3] && vld[4])

endmodule

`default_nettype wire

// ===== rtl/sit_cross.sv =====
// one cross product lane: products, difference, then side and on-line flags
// depends on sit_pkg; stage enables come from the top level
`default_nettype none

module sit_cross #(
  parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEFAULT
) (
  input  wire logic                               clk,
  input  wire sit_pkg::sit_adv_t                  adv,
  input  wire logic signed [COORD_WIDTH:0]        dx,
  input  wire logic signed [COORD_WIDTH:0]        dy,
  input  wire logic signed [COORD_WIDTH:0]        qx,
  input  wire logic signed [COORD_WIDTH:0]        qy,
  input  wire logic [sit_pkg::TOL_WIDTH-1:0]      tol,
  output logic                                    on,
  output logic                                    right
);

  localparam int DW   = COORD_WIDTH + 1;
  localparam int PW   = 2 * DW;
  localparam int XW   = PW + 1;
  localparam int CMPW = (XW > sit_pkg::TOL_WIDTH) ? XW : sit_pkg::TOL_WIDTH;

  logic signed [PW-1:0] p_dq;
  logic signed [PW-1:0] p_qd;
  logic signed [XW-1:0] xprod;
  logic [XW-1:0]        xprod_u;
  logic [XW-1:0]        mag;

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      p_dq <= dx * qy;
      p_qd <= qx * dy;
    end
    if (adv.s3) begin
      xprod <= XW'(p_dq) - XW'(p_qd);
    end
  end

  always_comb begin
    xprod_u = xprod;
    mag     = xprod_u[XW-1] ? (~xprod_u + 1'b1) : xprod_u;
    on      = CMPW'(mag) < CMPW'(tol);
    right   = xprod_u[XW-1];
  end

endmodule

`default_nettype wire
